### src/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg
// Types and constants shared by the interpolator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package pci_pkg;
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RW_ZERO  = 2'd1,
    ST_WS_ZERO  = 2'd2
  } status_e;

  localparam int unsigned DivBits = 64;
  localparam int unsigned DivStep = 4;  // quotient bits per pipeline stage
  localparam int unsigned DivStages = DivBits / DivStep;
endpackage
`default_nettype wire

### src/pci_div.sv
// ----------------------------------------------------------------------------
// pci_div
// Pipelined unsigned 64/64 restoring divider, DivStep quotient bits a stage.
// Carries a side band word along with the operands.
// ----------------------------------------------------------------------------
`default_nettype none
module pci_div #(
  parameter int unsigned SideW = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire logic                        valid_i,
  input  wire logic [pci_pkg::DivBits-1:0] num_i,
  input  wire logic [pci_pkg::DivBits-1:0] den_i,
  input  wire logic [SideW-1:0]            side_i,
  output logic                             valid_o,
  output logic [pci_pkg::DivBits-1:0]      quo_o,
  output logic [SideW-1:0]                 side_o
);
  localparam int unsigned N = pci_pkg::DivBits;
  localparam int unsigned S = pci_pkg::DivStages;
  localparam int unsigned K = pci_pkg::DivStep;

  logic [S:0]           vld_q;
  logic [N-1:0]         rem_q  [S+1];
  logic [N-1:0]         num_q  [S+1];
  logic [N-1:0]         den_q  [S+1];
  logic [SideW-1:0]     side_q [S+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = '0;
    num_q[0]  = num_i;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [N-1:0] rem_d, num_d;
    always_comb begin
      logic [N:0] r;
      r = {1'b0, rem_q[s]};
      num_d = num_q[s];
      for (int b = 0; b < K; b++) begin
        r = {r[N-1:0], num_d[N-1]};
        num_d = {num_d[N-2:0], 1'b0};
        if (r >= {1'b0, den_q[s]}) begin
          r = r - {1'b0, den_q[s]};
          num_d[0] = 1'b1;
        end
      end
      rem_d = r[N-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1]  <= rem_d;
        num_q[s+1]  <= num_d;
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[S];
  assign quo_o   = num_q[S];
  assign side_o  = side_q[S];
endmodule
`default_nettype wire

### src/pci_front.sv
// ----------------------------------------------------------------------------
// pci_front
// Products and sums: two register stages ahead of the dividers.
// ----------------------------------------------------------------------------
`default_nettype none
module pci_front #(
  parameter int unsigned PreShift = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] w_i   [3],
  input  wire logic signed [31:0] rw_i  [3],
  input  wire logic        [30:0] z_i   [3],
  input  wire logic signed [31:0] at_i  [3],
  output logic                    valid_o,
  output logic        [63:0]      wsum_o,
  output logic        [63:0]      zacc_o,
  output logic        [63:0]      racc_o,
  output logic        [63:0]      aacc_o
);
  localparam int unsigned PsEff = (PreShift > 63) ? 63 : PreShift;

  logic               v1_q, v2_q;
  logic signed [63:0] zp_q [3], rp_q [3], ap_q [3];
  logic signed [31:0] w1_q [3];
  logic        [63:0] ws1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        zp_q[k] <= $signed({1'b0, z_i[k]}) * 64'(w_i[k]);
        rp_q[k] <= 64'(w_i[k]) * 64'(rw_i[k]);
        ap_q[k] <= 64'(at_i[k]) * 64'(rw_i[k]);
        w1_q[k] <= w_i[k];
      end
      ws1_q <= 64'(w_i[0]) + 64'(w_i[1]) + 64'(w_i[2]);
    end
  end

  // second multiply: shifted attribute product times weight, low 64 bits kept
  logic signed [63:0] as [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      as[k] = ap_q[k] >>> PsEff;
    end
  end

  // 64x32 product split into 32x32 partials; a negative weight adds -lo to the
  // upper word
  logic [63:0] awl_q [3];
  logic [31:0] awh_q [3];
  logic [63:0] z2_q, r2_q, ws2_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        awl_q[k] <= 64'(as[k][31:0]) * 64'($unsigned(w1_q[k]));
        awh_q[k] <= as[k][63:32] * $unsigned(w1_q[k])
                    + (w1_q[k][31] ? -as[k][31:0] : 32'd0);
      end
      z2_q  <= zp_q[0] + zp_q[1] + zp_q[2];
      r2_q  <= rp_q[0] + rp_q[1] + rp_q[2];
      ws2_q <= ws1_q;
    end
  end

  assign valid_o = v2_q;
  assign wsum_o  = ws2_q;
  assign zacc_o  = z2_q;
  assign racc_o  = r2_q;
  assign aacc_o  = awl_q[0] + awl_q[1] + awl_q[2]
                   + {awh_q[0] + awh_q[1] + awh_q[2], 32'd0};
endmodule
`default_nettype wire

### src/perspective_correct_interpolator.sv
// ----------------------------------------------------------------------------
// perspective_correct_interpolator: 21 register stages (2 front, 1 sign,
// 16 divider at 4 quotient bits a stage, 1 multiply, 1 output). Throughput: one
// beat per cycle; an output stall freezes the pipeline and the input. Reset
// (rst_ni low, async) clears valids.
// ----------------------------------------------------------------------------
`default_nettype none
module perspective_correct_interpolator #(
  parameter int unsigned RECIP_W_FRAC = 29,
  parameter int unsigned WEIGHT_FRAC  = 8,
  parameter int unsigned INV_W_FRAC   = 16,
  parameter int unsigned PRE_SHIFT    = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic signed [31:0] weight_a_i,
  input  wire logic signed [31:0] weight_b_i,
  input  wire logic signed [31:0] weight_c_i,
  input  wire logic signed [31:0] recip_w_a_i,
  input  wire logic signed [31:0] recip_w_b_i,
  input  wire logic signed [31:0] recip_w_c_i,
  input  wire logic        [30:0] depth_a_i,
  input  wire logic        [30:0] depth_b_i,
  input  wire logic        [30:0] depth_c_i,
  input  wire logic signed [31:0] attr_v0_i,
  input  wire logic signed [31:0] attr_v1_i,
  input  wire logic signed [31:0] attr_v2_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [31:0]      depth_out_o,
  output logic signed [63:0]      inv_w_out_o,
  output logic signed [31:0]      attr_out_o,
  output logic        [1:0]       status_o
);
  localparam int unsigned OneSh = RECIP_W_FRAC + WEIGHT_FRAC + INV_W_FRAC;
  localparam logic [63:0] OneVal = (OneSh >= 64) ? 64'd0 : (64'd1 << OneSh);
  localparam int          FinSh  = int'(RECIP_W_FRAC) - int'(PRE_SHIFT)
                                   + int'(WEIGHT_FRAC) + int'(INV_W_FRAC);
  localparam int unsigned RShift = (FinSh > 63) ? 63 : ((FinSh < 0) ? 0 : FinSh);
  localparam int unsigned LShift = (FinSh < 0) ? ((-FinSh > 63) ? 64 : -FinSh) : 0;

  // Output register holds while stalled; pipeline moves when output free.
  logic adv;
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  logic signed [31:0] w [3], rw [3], at [3];
  logic        [30:0] z [3];
  assign w  = '{weight_a_i, weight_b_i, weight_c_i};
  assign rw = '{recip_w_a_i, recip_w_b_i, recip_w_c_i};
  assign z  = '{depth_a_i, depth_b_i, depth_c_i};
  assign at = '{attr_v0_i, attr_v1_i, attr_v2_i};

  logic        f_v;
  logic [63:0] wsum, zacc, racc, aacc;
  pci_front #(.PreShift(PRE_SHIFT)) u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(valid_i),
    .w_i(w), .rw_i(rw), .z_i(z), .at_i(at),
    .valid_o(f_v), .wsum_o(wsum), .zacc_o(zacc), .racc_o(racc), .aacc_o(aacc)
  );

  // stage 3: status, magnitudes and signs
  logic        s3_v_q;
  logic [1:0]  s3_st_q;
  logic [63:0] zm_q, wm_q, rm_q, aacc3_q;
  logic        zneg_q, rneg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= f_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wsum == '0) begin
        s3_st_q <= pci_pkg::ST_WS_ZERO;
      end else if (racc == '0) begin
        s3_st_q <= pci_pkg::ST_RW_ZERO;
      end else begin
        s3_st_q <= pci_pkg::ST_OK;
      end
      zm_q    <= zacc[63] ? -zacc : zacc;
      wm_q    <= (wsum == '0) ? 64'd1 : (wsum[63] ? -wsum : wsum);
      rm_q    <= (racc == '0) ? 64'd1 : (racc[63] ? -racc : racc);
      zneg_q  <= zacc[63] ^ wsum[63];
      // a one constant at bit 63 counts as negative
      rneg_q  <= racc[63] ^ OneVal[63];
      aacc3_q <= aacc;
    end
  end

  localparam int unsigned SideW = 2 + 2 + 64;
  logic             dz_v, dr_v;
  logic [63:0]      qz, qr;
  logic [SideW-1:0] sz, sr;
  pci_div #(.SideW(SideW)) u_div_z (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s3_v_q),
    .num_i(zm_q), .den_i(wm_q), .side_i({s3_st_q, zneg_q, rneg_q, aacc3_q}),
    .valid_o(dz_v), .quo_o(qz), .side_o(sz)
  );
  pci_div #(.SideW(SideW)) u_div_r (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s3_v_q),
    .num_i(OneVal), .den_i(rm_q), .side_i({s3_st_q, zneg_q, rneg_q, aacc3_q}),
    .valid_o(dr_v), .quo_o(qr), .side_o(sr)
  );

  // apply signs; attribute sum times |1/W| as 32x32 partials, sign applied later
  logic        m_v_q;
  logic [1:0]  m_st_q;
  logic [63:0] m_z_q, m_iw_q, m_ll_q;
  logic [31:0] m_x_q;
  logic        m_pneg_q;
  logic [63:0] iw;
  assign iw = sz[64] ? -qr : qr;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (adv) begin
      m_v_q <= dz_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_st_q   <= sz[67:66];
      m_z_q    <= sz[65] ? -qz : qz;
      m_iw_q   <= iw;
      m_ll_q   <= 64'(sz[31:0]) * 64'(qr[31:0]);
      m_x_q    <= sz[63:32] * qr[31:0] + sz[31:0] * qr[63:32];
      m_pneg_q <= sz[64];
    end
  end

  // output register
  logic        [63:0] p_abs, p_sum;
  logic signed [63:0] attr_w;
  always_comb begin
    p_abs = m_ll_q + {m_x_q, 32'd0};
    p_sum = m_pneg_q ? -p_abs : p_abs;
    if (LShift >= 64) begin
      attr_w = '0;
    end else if (LShift > 0) begin
      attr_w = $signed(p_sum << LShift);
    end else begin
      attr_w = $signed(p_sum) >>> RShift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= m_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_o <= m_st_q;
      if (m_st_q == pci_pkg::ST_OK) begin
        depth_out_o <= m_z_q[31:0];
        inv_w_out_o <= m_iw_q;
        attr_out_o  <= attr_w[31:0];
      end else begin
        depth_out_o <= '0;
        inv_w_out_o <= '0;
        attr_out_o  <= '0;
      end
    end
  end

  logic unused;
  assign unused = dr_v ^ (^sr);
endmodule
`default_nettype wire

### src/pci_checker.sv
// ----------------------------------------------------------------------------
// pci_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pci_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic        stall_o,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] depth_out_o,
  input wire logic [63:0] inv_w_out_o
);
  logic out_busy, status_known, err_beat, out_zero;
  assign out_busy     = valid_o && stall_i;
  assign status_known = (status_o == pci_pkg::ST_OK) || (status_o == pci_pkg::ST_RW_ZERO)
                        || (status_o == pci_pkg::ST_WS_ZERO);
  assign err_beat     = valid_o && (status_o != pci_pkg::ST_OK);
  assign out_zero     = (depth_out_o == 32'd0) && (inv_w_out_o == 64'd0);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_busy, valid_o && $stable(inv_w_out_o), "beat changed")
  `ASSERT_IMPLIES(a_stall_link, clk_i, rst_ni, stall_o, out_busy, "input stall without output stall")
  `ASSERT_IMPLIES(a_status_code, clk_i, rst_ni, valid_o, status_known, "bad status code")
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, err_beat, out_zero, "error result not zero")
endmodule

bind perspective_correct_interpolator pci_checker u_pci_checker (
  .clk_i, .rst_ni, .valid_o, .stall_i, .stall_o, .status_o, .depth_out_o, .inv_w_out_o
);
`default_nettype wire
